/* src/cdata_marker_stripper_defines.svh */
// ---------------------------------------------------------------------------
// CDATA marker stripper assertion macros
// Shared overlapping-implication and next-cycle checks, clocked on clk and
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CDATA_MARKER_STRIPPER_DEFINES_SVH
`define CDATA_MARKER_STRIPPER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cdms_pkg.sv */
// ---------------------------------------------------------------------------
// cdms_pkg
// Types, marker strings and match helpers for the CDATA marker stripper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdms_pkg;

    localparam int WIN_DEPTH = 9;
    localparam int OPEN_LEN  = 9;
    localparam int CLOSE_LEN = 3;

    localparam logic [8*OPEN_LEN-1:0]  OPEN_STR  = "<![cdata[";
    localparam logic [8*CLOSE_LEN-1:0] CLOSE_STR = "]]>";

    typedef logic [7:0] byte_t;
    typedef byte_t [WIN_DEPTH-1:0] win_t;
    typedef logic [3:0] fill_t;

    typedef enum logic [1:0] {
        DEC_EMIT,
        DEC_OPEN,
        DEC_CLOSE
    } dec_kind_t;

    typedef struct packed {
        dec_kind_t kind;
        byte_t     head;
        logic      final_emit;
    } decision_t;

    // Fold ASCII upper case letters to lower case; everything else as is.
    function automatic byte_t fold_case(byte_t c);
        byte_t r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic opens_at(win_t w);
        logic hit;
        hit = 1'b1;
        for (int k = 0; k < OPEN_LEN; k++)
        begin
            if (fold_case(w[k]) != OPEN_STR[8*(OPEN_LEN-1-k) +: 8])
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic closes_at(byte_t a, byte_t b, byte_t c);
        return (a == CLOSE_STR[23:16]) && (b == CLOSE_STR[15:8]) && (c == CLOSE_STR[7:0]);
    endfunction

    // Drop n bytes from the front of the window; the tail is don't care.
    function automatic win_t shift_win(win_t w, int unsigned n);
        win_t r;
        r = w;
        for (int unsigned i = 0; i < WIN_DEPTH; i++)
        begin
            if (i + n < WIN_DEPTH)
            begin
                r[i] = w[i + n];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/cdms_head_decide.sv */
// ---------------------------------------------------------------------------
// cdms_head_decide
// Decides the head of the look-ahead window: open marker, close marker or
// pass-through byte, and whether an emitted byte is the last of a drain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdms_head_decide (
    input  wire cdms_pkg::win_t      win,
    input  wire cdms_pkg::fill_t     fill,
    input  wire logic                in_section,
    output cdms_pkg::decision_t      dec
);

    logic open_hit;
    logic close_hit;
    logic tail_close;

    always_comb
    begin
        open_hit  = (fill == cdms_pkg::fill_t'(cdms_pkg::OPEN_LEN)) && cdms_pkg::opens_at(win);
        close_hit = in_section && (fill >= cdms_pkg::fill_t'(cdms_pkg::CLOSE_LEN))
                    && cdms_pkg::closes_at(win[0], win[1], win[2]);
        // After emitting the head, only a trailing close marker could still drop bytes.
        tail_close = in_section && (fill == cdms_pkg::fill_t'(cdms_pkg::CLOSE_LEN + 1))
                     && cdms_pkg::closes_at(win[1], win[2], win[3]);

        dec.head       = win[0];
        dec.final_emit = (fill <= 4'd1) || tail_close;
        if (open_hit)
        begin
            dec.kind = cdms_pkg::DEC_OPEN;
        end
        else if (close_hit)
        begin
            dec.kind = cdms_pkg::DEC_CLOSE;
        end
        else
        begin
            dec.kind = cdms_pkg::DEC_EMIT;
        end
    end

endmodule

`default_nettype wire

/* src/cdata_marker_stripper.sv */
// ---------------------------------------------------------------------------
// cdata_marker_stripper
// Byte stream filter that removes CDATA open and close markers.
// ---------------------------------------------------------------------------
// Input channel: data_byte and end_of_doc, transfer when in_valid is high
// and in_stall is low. Output channel: out_byte, byte_valid, out_last,
// transfer when out_valid is high and out_stall is low.
// Bytes are held in a nine-byte look-ahead window. While the window fills,
// no result appears; after that each accepted byte gives at most one result
// in the next cycle; one byte is taken every cycle while in_stall is low.
// On the byte flagged end_of_doc the window drains one head decision per
// cycle while the output is free; in_stall stays high until the drain ends.
// The last result carries out_last; a document that leaves nothing gives one
// result with byte_valid low and out_last high.
// A single output register sits between the sides: when it is full and
// out_stall is high, everything holds and in_stall rises.
// Reset empties the window and clears the section, drain and valid flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cdata_marker_stripper_defines.svh"

module cdata_marker_stripper (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_doc,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            out_last
);

    cdms_pkg::win_t      win_reg, win_next;
    cdms_pkg::fill_t     fill_reg, fill_next;
    logic                inside_reg, inside_next;
    logic                drain_reg, drain_next;
    logic                emitted_reg, emitted_next;

    logic                out_valid_reg, out_valid_next;
    cdms_pkg::byte_t     out_byte_reg, out_byte_next;
    logic                byte_valid_reg, byte_valid_next;
    logic                out_last_reg, out_last_next;

    cdms_pkg::win_t      ext_win;
    cdms_pkg::win_t      dec_win;
    cdms_pkg::fill_t     dec_fill;
    cdms_pkg::decision_t dec;

    logic                out_free;
    logic                in_take;
    logic                load;
    cdms_pkg::byte_t     ld_byte;
    logic                ld_valid;
    logic                ld_last;

    cdms_head_decide u_decide (
        .win        (dec_win),
        .fill       (dec_fill),
        .in_section (inside_reg),
        .dec        (dec)
    );

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        in_stall = drain_reg || !out_free;
        in_take  = in_valid && !in_stall;

        for (int i = 0; i < cdms_pkg::WIN_DEPTH; i++)
        begin
            ext_win[i] = (fill_reg == cdms_pkg::fill_t'(i)) ? data_byte : win_reg[i];
        end
        dec_win  = drain_reg ? win_reg : ext_win;
        dec_fill = drain_reg ? fill_reg : fill_reg + 4'd1;
    end

    // Window and section control
    always_comb
    begin
        win_next     = win_reg;
        fill_next    = fill_reg;
        inside_next  = inside_reg;
        drain_next   = drain_reg;
        emitted_next = emitted_reg;
        load         = 1'b0;
        ld_byte      = dec.head;
        ld_valid     = 1'b1;
        ld_last      = 1'b0;

        if (drain_reg && out_free)
        begin
            case (dec.kind)
                cdms_pkg::DEC_EMIT:
                begin
                    load    = 1'b1;
                    ld_last = dec.final_emit;
                    if (dec.final_emit)
                    begin
                        fill_next   = '0;
                        inside_next = 1'b0;
                        drain_next  = 1'b0;
                    end
                    else
                    begin
                        win_next     = cdms_pkg::shift_win(win_reg, 1);
                        fill_next    = fill_reg - 4'd1;
                        emitted_next = 1'b1;
                    end
                end
                cdms_pkg::DEC_OPEN:
                begin
                    // Open marker swallows the whole window and ends the document.
                    fill_next   = '0;
                    inside_next = 1'b0;
                    drain_next  = 1'b0;
                    load        = !emitted_reg;
                    ld_byte     = '0;
                    ld_valid    = 1'b0;
                    ld_last     = 1'b1;
                end
                cdms_pkg::DEC_CLOSE:
                begin
                    inside_next = 1'b0;
                    if (fill_reg == cdms_pkg::fill_t'(cdms_pkg::CLOSE_LEN))
                    begin
                        fill_next  = '0;
                        drain_next = 1'b0;
                        load       = !emitted_reg;
                        ld_byte    = '0;
                        ld_valid   = 1'b0;
                        ld_last    = 1'b1;
                    end
                    else
                    begin
                        win_next  = cdms_pkg::shift_win(win_reg, cdms_pkg::CLOSE_LEN);
                        fill_next = fill_reg - cdms_pkg::fill_t'(cdms_pkg::CLOSE_LEN);
                    end
                end
                default:
                begin
                    drain_next = drain_reg;
                end
            endcase
        end
        else if (in_take)
        begin
            if (end_of_doc)
            begin
                win_next     = ext_win;
                fill_next    = fill_reg + 4'd1;
                drain_next   = 1'b1;
                emitted_next = 1'b0;
            end
            else if (dec_fill == cdms_pkg::fill_t'(cdms_pkg::WIN_DEPTH))
            begin
                case (dec.kind)
                    cdms_pkg::DEC_EMIT:
                    begin
                        load      = 1'b1;
                        win_next  = cdms_pkg::shift_win(ext_win, 1);
                        fill_next = cdms_pkg::fill_t'(cdms_pkg::WIN_DEPTH - 1);
                    end
                    cdms_pkg::DEC_OPEN:
                    begin
                        fill_next   = '0;
                        inside_next = 1'b1;
                    end
                    cdms_pkg::DEC_CLOSE:
                    begin
                        win_next    = cdms_pkg::shift_win(ext_win, cdms_pkg::CLOSE_LEN);
                        fill_next   = cdms_pkg::fill_t'(cdms_pkg::WIN_DEPTH - cdms_pkg::CLOSE_LEN);
                        inside_next = 1'b0;
                    end
                    default:
                    begin
                        win_next = ext_win;
                    end
                endcase
            end
            else
            begin
                win_next  = ext_win;
                fill_next = fill_reg + 4'd1;
            end
        end
    end

    // Output register: load when free, hold while stalled
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        out_last_next   = out_last_reg;
        if (out_free)
        begin
            out_valid_next  = load;
            out_byte_next   = ld_byte;
            byte_valid_next = ld_valid;
            out_last_next   = ld_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            inside_reg    <= 1'b0;
            drain_reg     <= 1'b0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            inside_reg    <= inside_next;
            drain_reg     <= drain_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg        <= win_next;
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign out_last   = out_last_reg;

    `CDMS_ASSERT_SAME(a_fill_bound, !drain_reg, fill_reg <= 4'd8, "window overfull between bytes")
    `CDMS_ASSERT_NEXT(a_drain_start, in_take && end_of_doc, drain_reg,
                      "drain did not start on last byte")
    `CDMS_ASSERT_NEXT(a_drain_end, out_free && load && ld_last,
                      !drain_reg && fill_reg == 4'd0 && !inside_reg, "state not cleared after last result")
    `CDMS_ASSERT_SAME(a_empty_is_last, out_valid_reg && !byte_valid_reg, out_last_reg,
                      "empty result without last flag")
    `CDMS_ASSERT_SAME(a_drain_stall, drain_reg, in_stall, "input accepted during drain")

endmodule

`default_nettype wire
